FILE: design/pmrgb_pkg.sv
// ----------------------------------------------------------------------------
// pmrgb_pkg
// Shared types and constants for the mask-driven pixel to RGB888 converter.
// ----------------------------------------------------------------------------
package pmrgb_pkg;

  localparam int WORD_BITS    = 32;
  localparam int CHANNEL_BITS = 8;
  localparam int SHIFT_BITS   = 5;
  localparam int WIDTH_BITS   = 4;
  localparam int INDEX_BITS   = 2;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_RED_MASK   = 2'd0,
    REG_GREEN_MASK = 2'd1,
    REG_BLUE_MASK  = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_index_t;

  localparam logic [WORD_BITS-1:0] RED_MASK_RESET   = 32'h00FF_0000;
  localparam logic [WORD_BITS-1:0] GREEN_MASK_RESET = 32'h0000_FF00;
  localparam logic [WORD_BITS-1:0] BLUE_MASK_RESET  = 32'h0000_00FF;

  // decoded channel: field position and width (0 means channel reads as 0)
  typedef struct packed {
    logic [SHIFT_BITS-1:0] shift;
    logic [WIDTH_BITS-1:0] width;
  } chan_cfg_t;

endpackage

FILE: design/pixel_mask_to_rgb888.sv
// ----------------------------------------------------------------------------
// pixel_mask_to_rgb888
// Converts packed pixel words into RGB888 using three channel masks.
// ----------------------------------------------------------------------------
// One pixel per clock while the output is not stalled: the pixel is
// registered, each channel field is cut out and left-aligned, and the RGB
// result is registered. The masks are decoded into shift and width when
// written, so a write must land before the pixels that use it. A mask with no
// set bit in the low PIXEL_BITS bits gives 0; only its lowest run of ones is
// used, and a run over 8 bits keeps its top 8 bits.
module pixel_mask_to_rgb888
  import pmrgb_pkg::*;
#(
  parameter int PIXEL_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [INDEX_BITS-1:0] wr_index,
  input  logic [WORD_BITS-1:0]  wr_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [31:0] pixel_word
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata    // [7:0] red_out, [15:8] green_out,
                                           // [23:16] blue_out
);

  chan_cfg_t red_cfg;
  chan_cfg_t green_cfg;
  chan_cfg_t blue_cfg;

  logic                    in_valid;
  logic [WORD_BITS-1:0]    pixel;
  logic                    advance;
  logic [CHANNEL_BITS-1:0] red_value;
  logic [CHANNEL_BITS-1:0] green_value;
  logic [CHANNEL_BITS-1:0] blue_value;

  pmrgb_cfg_regs #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .red_cfg  (red_cfg),
    .green_cfg(green_cfg),
    .blue_cfg (blue_cfg)
  );

  pmrgb_channel u_red   (.pixel(pixel), .cfg(red_cfg),   .value(red_value));
  pmrgb_channel u_green (.pixel(pixel), .cfg(green_cfg), .value(green_value));
  pmrgb_channel u_blue  (.pixel(pixel), .cfg(blue_cfg),  .value(blue_value));

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      pixel <= s_tdata;
    end
    if (advance && in_valid) begin
      m_tdata <= {blue_value, green_value, red_value};
    end
  end

  // request taken into the input stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted request not held in input stage");

  // empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  // a stalled input stage keeps its request
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(pixel))
    else $error("input stage lost a stalled request");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    red_cfg.width <= WIDTH_BITS'(CHANNEL_BITS) &&
    green_cfg.width <= WIDTH_BITS'(CHANNEL_BITS) &&
    blue_cfg.width <= WIDTH_BITS'(CHANNEL_BITS))
    else $error("decoded channel width above 8");

endmodule

FILE: design/pmrgb_cfg_regs.sv
// ----------------------------------------------------------------------------
// pmrgb_cfg_regs
// Channel mask registers, held in decoded form (shift and width of the field).
// ----------------------------------------------------------------------------
module pmrgb_cfg_regs
  import pmrgb_pkg::*;
#(
  parameter int PIXEL_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [INDEX_BITS-1:0] wr_index,
  input  logic [WORD_BITS-1:0]  wr_data,
  output chan_cfg_t             red_cfg,
  output chan_cfg_t             green_cfg,
  output chan_cfg_t             blue_cfg
);

  localparam logic [WORD_BITS-1:0] USED_MASK =
    WORD_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

  // index of the single set bit of a one-hot word
  function automatic logic [SHIFT_BITS:0] onehot_index(logic [WORD_BITS:0] oh);
    logic [SHIFT_BITS:0] idx;
    idx = '0;
    for (int i = 0; i <= WORD_BITS; i++) begin
      if (oh[i]) begin
        idx = idx | (SHIFT_BITS+1)'(i);
      end
    end
    return idx;
  endfunction

  // lowest run of ones: adding its lowest bit carries to the bit past its end
  function automatic chan_cfg_t decode(logic [WORD_BITS-1:0] mask,
                                       logic [WORD_BITS-1:0] used);
    logic [WORD_BITS-1:0] m;
    logic [WORD_BITS-1:0] low;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS:0]   sum_low;
    logic [SHIFT_BITS:0]  lsb;
    logic [SHIFT_BITS:0]  stop;
    logic [SHIFT_BITS:0]  run;
    chan_cfg_t            c;
    m       = mask & used;
    low     = m & (~m + WORD_BITS'(1));
    sum     = {1'b0, m} + {1'b0, low};
    sum_low = sum & (~sum + (WORD_BITS+1)'(1));
    lsb     = onehot_index({1'b0, low});
    stop    = onehot_index(sum_low);
    run     = stop - lsb;
    if (m == '0) begin
      c.shift = '0;
      c.width = '0;
    end else if (run > (SHIFT_BITS+1)'(CHANNEL_BITS)) begin
      c.shift = SHIFT_BITS'(stop - (SHIFT_BITS+1)'(CHANNEL_BITS));
      c.width = WIDTH_BITS'(CHANNEL_BITS);
    end else begin
      c.shift = lsb[SHIFT_BITS-1:0];
      c.width = run[WIDTH_BITS-1:0];
    end
    return c;
  endfunction

  localparam chan_cfg_t RED_RESET   = decode(RED_MASK_RESET, USED_MASK);
  localparam chan_cfg_t GREEN_RESET = decode(GREEN_MASK_RESET, USED_MASK);
  localparam chan_cfg_t BLUE_RESET  = decode(BLUE_MASK_RESET, USED_MASK);

  chan_cfg_t wr_cfg;
  assign wr_cfg = decode(wr_data, USED_MASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_cfg   <= RED_RESET;
      green_cfg <= GREEN_RESET;
      blue_cfg  <= BLUE_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_RED_MASK:   red_cfg   <= wr_cfg;
        REG_GREEN_MASK: green_cfg <= wr_cfg;
        REG_BLUE_MASK:  blue_cfg  <= wr_cfg;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/pmrgb_channel.sv
// ----------------------------------------------------------------------------
// pmrgb_channel
// Extracts one channel field from a pixel word and left-aligns it in 8 bits.
// ----------------------------------------------------------------------------
module pmrgb_channel
  import pmrgb_pkg::*;
(
  input  logic [WORD_BITS-1:0]    pixel,
  input  chan_cfg_t               cfg,
  output logic [CHANNEL_BITS-1:0] value
);

  logic [WORD_BITS-1:0]    shifted;
  logic [CHANNEL_BITS-1:0] keep;
  logic [CHANNEL_BITS-1:0] field;
  logic [WIDTH_BITS-1:0]   pad;

  always_comb begin
    shifted = pixel >> cfg.shift;
    keep    = CHANNEL_BITS'((9'd1 << cfg.width) - 9'd1);
    field   = shifted[CHANNEL_BITS-1:0] & keep;
    pad     = WIDTH_BITS'(CHANNEL_BITS) - cfg.width;
    value   = field << pad;
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the mask-driven pixel to RGB888 converter. A table of directed
// pixels and mask settings is run first, then random pixels under random, empty,
// full and reset masks. Each result is checked against the table or a local model
// of the channel extraction, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_top;
  import pmrgb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_PIXELS   = 95;
  localparam int HOLDOFF_AT     = 420;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef enum logic {ROW_MASKS, ROW_PIXEL} row_kind_t;

  // a,b,c: masks (red, green, blue) or pixel in a; exp is {blue, green, red}
  typedef struct packed {
    row_kind_t        kind;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [31:0]      c;
    logic             has_exp;
    rgb_t             exp;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_index;
  logic [WORD_BITS-1:0]  wr_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;   // [31:0] pixel_word
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;   // [7:0] red_out, [15:8] green_out, [23:16] blue_out

  logic [31:0] mask_copy [3];
  rgb_t        rgb_due [$];
  dir_row_t    dir_rows [$];

  int errors       = 0;
  int n_pixels     = 0;
  int n_results    = 0;
  int n_writes     = 0;
  int n_settings   = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;
  bit holdoff_go   = 1'b0;
  bit holdoff_done = 1'b0;

  pixel_mask_to_rgb888 dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] channel_value(input logic [31:0] mask, input logic [31:0] pix);
    int          lo;
    int          run;
    logic [31:0] field;
    logic [7:0]  f8;
    if (mask == 32'd0) return 8'd0;
    lo = 0;
    while (lo < 32 && !mask[lo]) lo++;
    run = 0;
    while (lo + run < 32 && mask[lo + run]) run++;
    if (run > 8) begin
      lo  = lo + run - 8;
      run = 8;
    end
    field = (pix >> lo) & ((32'd1 << run) - 32'd1);
    f8 = field[7:0];
    return f8 << (8 - run);
  endfunction

  function automatic rgb_t convert_pixel(input logic [31:0] pix);
    rgb_t r;
    r.red   = channel_value(mask_copy[REG_RED_MASK], pix);
    r.green = channel_value(mask_copy[REG_GREEN_MASK], pix);
    r.blue  = channel_value(mask_copy[REG_BLUE_MASK], pix);
    return r;
  endfunction

  function automatic logic [31:0] pick_mask();
    int sh;
    int wd;
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: begin
        sh = $urandom_range(0, 31);
        wd = $urandom_range(1, 32 - sh);
        return 32'((64'd1 << wd) - 64'd1) << sh;
      end
      3: begin
        sh = $urandom_range(0, 24);
        wd = $urandom_range(1, 8);
        return ((32'd1 << wd) - 32'd1) << sh;
      end
      4: return 32'd1 << $urandom_range(0, 31);
      5: return $urandom();
      6: return 32'h0000_00FF << (8 * $urandom_range(0, 3));
      default: begin
        sh = $urandom_range(0, 20);
        wd = $urandom_range(1, 10);
        return (((32'd1 << wd) - 32'd1) << sh) | (32'd1 << $urandom_range(sh + wd + 1, 31));
      end
    endcase
  endfunction

  task automatic add_row(input dir_row_t row);
    dir_rows = {dir_rows, row};
  endtask

  // caller is at a falling edge; leaves at a falling edge with wr_en low
  task automatic set_masks(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b);
    logic [31:0] vals [3];
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (rgb_due.size() != 0) @(negedge clk);
    vals[0] = r;
    vals[1] = g;
    vals[2] = b;
    for (int i = 0; i < 3; i++) begin
      wr_en    <= 1'b1;
      wr_index <= reg_index_t'(i);
      wr_data  <= vals[i];
      mask_copy[i] = vals[i];
      @(negedge clk);
    end
    // the spare index must be ignored
    wr_index <= REG_UNUSED;
    wr_data  <= $urandom();
    @(negedge clk);
    wr_en    <= 1'b0;
    n_writes   += 4;
    n_settings++;
  endtask

  task automatic offer_pixel(input logic [31:0] pix, input logic has_exp, input rgb_t exp);
    int   gap;
    rgb_t due;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    due = has_exp ? exp : convert_pixel(pix);
    rgb_due = {rgb_due, due};
    n_pixels++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    rgb_t want;
    rgb_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      n_results++;
      if (rgb_due.size() == 0) begin
        $display("%0t: result %06h with no request outstanding", $time, got);
        errors++;
      end else begin
        want = rgb_due.pop_front();
        if (got.red !== want.red) begin
          $display("%0t: red_out expected %02h got %02h", $time, want.red, got.red);
          errors++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green_out expected %02h got %02h", $time, want.green, got.green);
          errors++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue_out expected %02h got %02h", $time, want.blue, got.blue);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  // output side: changing stall patterns, plus one long hold-off
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_go && !holdoff_done) begin
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_done = 1'b1;
        m_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] pix;
    logic [31:0] all_masks;
    dir_row_t    row;

    rst      = 1'b1;
    wr_en    = 1'b0;
    wr_index = REG_RED_MASK;
    wr_data  = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    mask_copy[REG_RED_MASK]   = RED_MASK_RESET;
    mask_copy[REG_GREEN_MASK] = GREEN_MASK_RESET;
    mask_copy[REG_BLUE_MASK]  = BLUE_MASK_RESET;

    // reset masks
    add_row({ROW_PIXEL, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 24'h000000});
    add_row({ROW_PIXEL, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 24'hFFFFFF});
    add_row({ROW_PIXEL, 32'h00AA_BBCC, 32'h0, 32'h0, 1'b1, 24'hCCBBAA});
    add_row({ROW_PIXEL, 32'hFF00_0000, 32'h0, 32'h0, 1'b1, 24'h000000});
    add_row({ROW_PIXEL, 32'h0080_0101, 32'h0, 32'h0, 1'b1, 24'h010180});
    // empty red, full-word green, narrow blue
    add_row({ROW_MASKS, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_000F, 1'b0, 24'h0});
    add_row({ROW_PIXEL, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 24'hF0FF00});
    add_row({ROW_PIXEL, 32'h1234_5678, 32'h0, 32'h0, 1'b1, 24'h801200});
    add_row({ROW_PIXEL, 32'h0000_0000, 32'h0, 32'h0, 1'b1, 24'h000000});
    // split run in red, single top and bottom bits
    add_row({ROW_MASKS, 32'h000F_00F0, 32'h8000_0000, 32'h0000_0001, 1'b0, 24'h0});
    add_row({ROW_PIXEL, 32'h8000_00F1, 32'h0, 32'h0, 1'b1, 24'h8080F0});
    add_row({ROW_PIXEL, 32'h7FFF_FF0E, 32'h0, 32'h0, 1'b1, 24'h000000});
    add_row({ROW_PIXEL, 32'h000F_0000, 32'h0, 32'h0, 1'b0, 24'h0});
    // wide runs that keep their top bits, and a split run in green
    add_row({ROW_MASKS, 32'h0001_FFFF, 32'hF0F0_F0F0, 32'hFFFF_FFFE, 1'b0, 24'h0});
    add_row({ROW_PIXEL, 32'h0001_FE00, 32'h0, 32'h0, 1'b0, 24'h0});
    add_row({ROW_PIXEL, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 24'hFFF0FF});
    add_row({ROW_PIXEL, 32'h5A5A_5A5A, 32'h0, 32'h0, 1'b0, 24'h0});
    add_row({ROW_PIXEL, 32'hA5A5_A5A5, 32'h0, 32'h0, 1'b0, 24'h0});
    add_row({ROW_MASKS, 32'h8000_0001, 32'hFFFF_FF00, 32'h0000_01FE, 1'b0, 24'h0});
    add_row({ROW_PIXEL, 32'h0123_4567, 32'h0, 32'h0, 1'b0, 24'h0});
    add_row({ROW_PIXEL, 32'h89AB_CDEF, 32'h0, 32'h0, 1'b0, 24'h0});
    add_row({ROW_PIXEL, 32'hDEAD_BEEF, 32'h0, 32'h0, 1'b0, 24'h0});
    add_row({ROW_MASKS, RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET,
             1'b0, 24'h0});
    add_row({ROW_PIXEL, 32'h0012_3456, 32'h0, 32'h0, 1'b1, 24'h563412});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_MASKS)
        set_masks(row.a, row.b, row.c);
      else
        offer_pixel(row.a, row.has_exp, row.exp);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_masks(32'd0, 32'd0, 32'd0);
        1: set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        RANDOM_PHASES - 1: set_masks(RED_MASK_RESET, GREEN_MASK_RESET, BLUE_MASK_RESET);
        default: set_masks(pick_mask(), pick_mask(), pick_mask());
      endcase
      all_masks = mask_copy[0] | mask_copy[1] | mask_copy[2];
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        case ($urandom_range(0, 15))
          0: pix = 32'd0;
          1: pix = 32'hFFFF_FFFF;
          2: pix = all_masks;
          3: pix = ~all_masks;
          default: pix = $urandom();
        endcase
        if (n_pixels >= HOLDOFF_AT) holdoff_go = 1'b1;
        offer_pixel(pix, 1'b0, 24'h0);
      end
    end

    s_tvalid <= 1'b0;
    while (rgb_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d pixels, %0d results, %0d mask settings over %0d register writes",
             n_pixels, n_results, n_settings, n_writes);
    $display("output hold-off of %0d cycles %s", HOLDOFF_CYCLES,
             holdoff_done ? "taken with input backed up" : "not reached");
    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
design/pmrgb_pkg.sv
design/pmrgb_cfg_regs.sv
design/pmrgb_channel.sv
design/pixel_mask_to_rgb888.sv
bench/tb_top.sv
